@@ rtl/m521inv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package m521inv_pkg;

    // Word geometry of one field element: nine 64-bit words, 9 bits used in the top word.
    localparam int unsigned WordW   = 64;
    localparam int unsigned TopBits = 9;

    // Operand memory slots, nine words each.
    localparam logic [2:0] SL_E  = 3'd0;
    localparam logic [2:0] SL_T  = 3'd1;
    localparam logic [2:0] SL_T7 = 3'd2;
    localparam logic [2:0] SL_C7 = 3'd3;
    localparam logic [2:0] SL_C  = 3'd4;

    // Index of the final instruction of the exponentiation program.
    localparam logic [4:0] LastInstr = 5'd25;

    // One program step: dst = srca * srcb, then (reps - 1) squarings of dst in place.
    typedef struct packed {
        logic [2:0] dst;
        logic [2:0] srca;
        logic [2:0] srcb;
        logic [8:0] reps;
    } t_instr;

    // Partial product issue tag travelling with the operand memory read.
    typedef struct packed {
        logic valid;
        logic last;
        logic zero;
        logic hia;
        logic hib;
    } t_iss;

    // Product memory write strobe.
    typedef struct packed {
        logic       we;
        logic [4:0] addr;
    } t_pmw;

    // Operand memory write strobe, word index inside a slot.
    typedef struct packed {
        logic       we;
        logic [3:0] idx;
    } t_omw;

    // First word address of a slot: slot * 9.
    function automatic logic [5:0] slot_base(input logic [2:0] slot);
        slot_base = {slot, 3'b000} + {3'b000, slot};
    endfunction

    // Addition chain for x^(p-2), p = 2^521 - 1.
    function automatic t_instr chain_instr(input logic [4:0] pc);
        t_instr ins;
        ins = '{dst: SL_T, srca: SL_T, srcb: SL_T, reps: 9'd1};
        unique case (pc)
            5'd0:  ins = '{dst: SL_T,  srca: SL_E,  srcb: SL_E,  reps: 9'd1};
            5'd1:  ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_E,  reps: 9'd1};
            5'd2:  ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_T,  reps: 9'd1};
            5'd3:  ins = '{dst: SL_T7, srca: SL_T,  srcb: SL_E,  reps: 9'd1};
            5'd4:  ins = '{dst: SL_T,  srca: SL_T7, srcb: SL_T7, reps: 9'd1};
            5'd5:  ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_E,  reps: 9'd1};
            5'd6:  ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_T,  reps: 9'd3};
            5'd7:  ins = '{dst: SL_C7, srca: SL_T,  srcb: SL_T7, reps: 9'd1};
            5'd8:  ins = '{dst: SL_T,  srca: SL_C7, srcb: SL_C7, reps: 9'd1};
            5'd9:  ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_E,  reps: 9'd1};
            5'd10: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd8};
            5'd11: ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd12: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd16};
            5'd13: ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd14: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd32};
            5'd15: ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd16: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd64};
            5'd17: ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd18: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd128};
            5'd19: ins = '{dst: SL_C,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd20: ins = '{dst: SL_T,  srca: SL_C,  srcb: SL_C,  reps: 9'd256};
            5'd21: ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_C,  reps: 9'd1};
            5'd22: ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_T,  reps: 9'd7};
            5'd23: ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_C7, reps: 9'd1};
            5'd24: ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_T,  reps: 9'd2};
            5'd25: ins = '{dst: SL_T,  srca: SL_T,  srcb: SL_E,  reps: 9'd1};
            default: ins = '{dst: SL_T, srca: SL_T, srcb: SL_T, reps: 9'd1};
        endcase
        return ins;
    endfunction

endpackage

`default_nettype wire

@@ rtl/m521inv_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module m521inv_mac import m521inv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_iss              i_iss,
    input  wire logic [WordW-1:0]  i_rda,
    input  wire logic [WordW-1:0]  i_rdb,
    output t_pmw                   o_pw,
    output logic [WordW-1:0]       o_pdata,
    output logic                   o_done
);

    t_iss        r_s1;
    logic [63:0] r_prod;
    logic        r_pv;
    logic        r_pl;
    logic [71:0] r_acc;
    logic        r_sh;
    logic [31:0] r_lo;
    logic [5:0]  r_lc;

    logic [31:0] la;
    logic [31:0] lb;
    logic [63:0] n_prod;
    logic [71:0] n_base;
    logic [71:0] n_acc;

    // Limb selection from the registered memory words, then one 32x32 product.
    always_comb begin
        la     = r_s1.hia ? i_rda[63:32] : i_rda[31:0];
        lb     = r_s1.hib ? i_rdb[63:32] : i_rdb[31:0];
        n_prod = r_s1.zero ? 64'd0 : ({32'd0, la} * {32'd0, lb});
    end

    // Column accumulator: shifts down one limb after each finished column.
    always_comb begin
        n_base = r_sh ? {32'd0, r_acc[71:32]} : r_acc;
        n_acc  = n_base + (r_pv ? {8'd0, r_prod} : 72'd0);
    end

    assign o_done     = r_sh && (r_lc == 6'd33);
    assign o_pw.we    = r_sh && r_lc[0];
    assign o_pw.addr  = r_lc[5:1];
    assign o_pdata    = {r_acc[31:0], r_lo};

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_sh && !r_lc[0]) begin
            r_lo <= r_acc[31:0];
        end
    end

    // Pipeline control and product limb counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_pv  <= 1'b0;
            r_pl  <= 1'b0;
            r_sh  <= 1'b0;
            r_acc <= '0;
            r_lc  <= '0;
        end else begin
            r_s1 <= i_iss;
            r_pv <= r_s1.valid;
            r_pl <= r_s1.last;
            r_sh <= r_pv && r_pl;
            r_acc <= o_done ? 72'd0 : n_acc;
            if (r_sh) begin
                r_lc <= o_done ? 6'd0 : r_lc + 6'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/m521inv_red.sv @@
`timescale 1ns / 1ps
`default_nettype none

module m521inv_red import m521inv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_pmw              i_pw,
    input  wire logic [WordW-1:0]  i_pdata,
    input  wire logic              i_start,
    output t_omw                   o_ow,
    output logic [WordW-1:0]       o_odata,
    output logic                   o_done
);

    // Double-width product, 17 words.
    logic [63:0] r_pm [17];
    logic [63:0] r_px;
    logic [63:0] r_py;
    logic        r_yz;
    logic        r_busy;
    logic [3:0]  r_q;
    logic        r_dv;
    logic [3:0]  r_dq;
    logic [63:0] r_prev;
    logic        r_c;

    logic [4:0]  ax;
    logic [4:0]  ay;
    logic [63:0] py_eff;
    logic [3:0]  m;
    logic [63:0] hw;
    logic [63:0] lw;
    logic [64:0] sum;

    // Step 0 primes word 8; step q reads low word q-1 and high word q+8.
    always_comb begin
        ax = (r_q == 4'd0) ? 5'd0 : {1'b0, r_q - 4'd1};
        if (r_q == 4'd0) begin
            ay = 5'd8;
        end else if (r_q == 4'd9) begin
            ay = 5'd0;
        end else begin
            ay = {1'b0, r_q} + 5'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pw.we) begin
            r_pm[i_pw.addr] <= i_pdata;
        end
        r_px <= r_pm[ax];
        r_py <= r_pm[ay];
        r_yz <= (r_q == 4'd9);
    end

    // Low 521 bits plus the product shifted down by 521.
    always_comb begin
        py_eff = r_yz ? 64'd0 : r_py;
        m      = r_dq - 4'd1;
        hw     = {9'd0, r_prev[63:9]} | {py_eff[8:0], 55'd0};
        lw     = (m == 4'd8) ? {55'd0, r_px[8:0]} : r_px;
        sum    = {1'b0, lw} + {1'b0, hw} + {64'd0, r_c};
    end

    assign o_ow.we  = r_dv && (r_dq != 4'd0);
    assign o_ow.idx = m;
    assign o_odata  = sum[63:0];
    assign o_done   = r_dv && (r_dq == 4'd9);

    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_prev <= py_eff;
        end
        if (i_start) begin
            r_c <= 1'b0;
        end else if (r_dv && (r_dq != 4'd0)) begin
            r_c <= sum[64];
        end
    end

    // Step sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_q    <= '0;
            r_dv   <= 1'b0;
            r_dq   <= '0;
        end else begin
            r_dv <= r_busy;
            r_dq <= r_q;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= '0;
            end else if (r_busy) begin
                r_q <= r_q + 4'd1;
                if (r_q == 4'd9) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mersenne_521_field_inverse.sv @@
// Inverse in the prime field of order p = 2^521 - 1.
// Input channel: nine words (i_valid, i_in_word, o_stall), least significant first;
// bits 63..9 of the ninth word are ignored. The ninth word starts the inversion.
// Output channel: nine words (o_valid, o_out_word, o_last_word, i_stall), least
// significant first, o_last_word high on the ninth. Zero or p gives zero.
// One element is worked on at a time: o_stall is high from the ninth input word
// until the last result word has been taken.
// Work: 533 modular multiplications, each paced by the single 32x32 multiplier,
// which takes one of 290 partial products per cycle, followed by a pipeline drain,
// a reduction pass and a fold pass over the operand memory. Each result word is
// offered only after the previous one has been taken.
// Reset clears all control state and returns to loading; memory contents are not
// cleared. A stalled result word holds its value until taken.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_521_field_inverse import m521inv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [WordW-1:0]  i_in_word,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic [WordW-1:0]       o_out_word,
    output logic                   o_last_word,
    input  wire logic              i_stall
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_RED   = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_CHK   = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [3:0]  r_cnt;
    logic [4:0]  r_pc;
    logic [8:0]  r_rep;
    logic [5:0]  r_k;
    logic [4:0]  r_i;
    logic [3:0]  r_q;
    logic        r_pv;
    logic [3:0]  r_pq;
    logic        r_fc;
    logic        r_ones;
    logic        r_pow;
    logic        r_rdp;
    logic        r_ov;
    logic [63:0] r_ow;
    logic        r_ol;

    // Operand memory: five slots of nine words.
    logic [63:0] r_mem [45];
    logic [63:0] r_rda;
    logic [63:0] r_rdb;

    t_instr      ins;
    logic [2:0]  sla;
    logic [2:0]  slb;
    logic [4:0]  hi;
    logic [5:0]  j;
    logic [5:0]  k1;
    logic [4:0]  lo1;
    logic        col_last;
    t_iss        iss;
    logic [3:0]  fidx;
    logic [5:0]  addra;
    logic [5:0]  addrb;
    logic [3:0]  f_m;
    logic [63:0] f_lw;
    logic [64:0] f_sum;
    logic        om_we;
    logic [5:0]  om_waddr;
    logic [63:0] om_wdata;
    logic [63:0] out_fix;

    t_pmw        pw;
    logic [63:0] pdata;
    logic        mac_done;
    logic        red_start;
    t_omw        red_ow;
    logic [63:0] red_odata;
    logic        red_done;

    // Current program step and operand slots.
    always_comb begin
        ins = chain_instr(r_pc);
        sla = (r_rep == 9'd0) ? ins.srca : ins.dst;
        slb = (r_rep == 9'd0) ? ins.srcb : ins.dst;
    end

    // Product-scanning column walk; column 33 is a single zero product.
    always_comb begin
        hi       = (r_k > 6'd16) ? 5'd16 : r_k[4:0];
        j        = r_k - {1'b0, r_i};
        k1       = r_k + 6'd1;
        lo1      = (k1 > 6'd16) ? 5'(k1 - 6'd16) : 5'd0;
        col_last = (r_i == hi) || (r_k == 6'd33);
        iss.valid = (r_state == ST_MUL);
        iss.last  = col_last;
        iss.zero  = (r_k == 6'd33);
        iss.hia   = r_i[0];
        iss.hib   = j[0];
    end

    // Read addresses for both operand memory ports.
    always_comb begin
        fidx  = (r_q == 4'd0) ? 4'd8 : r_q - 4'd1;
        addra = slot_base(SL_T) + {2'd0, r_q};
        addrb = slot_base(slb) + {2'd0, j[4:1]};
        unique case (r_state) inside
            ST_MUL:         addra = slot_base(sla) + {2'd0, r_i[4:1]};
            ST_FOLD:        addra = slot_base(ins.dst) + {2'd0, fidx};
            ST_CHK, ST_OUT: addra = slot_base(SL_T) + {2'd0, r_q};
            default:        addra = slot_base(SL_T) + {2'd0, r_q};
        endcase
    end

    // Fold: add bit 521 back in at the bottom.
    always_comb begin
        f_m   = r_pq - 4'd1;
        f_lw  = (f_m == 4'd8) ? {55'd0, r_rda[8:0]} : r_rda;
        f_sum = {1'b0, f_lw} + {64'd0, r_fc};
    end

    // Single write port of the operand memory.
    always_comb begin
        om_we    = 1'b0;
        om_waddr = slot_base(SL_E) + {2'd0, r_cnt};
        om_wdata = i_in_word;
        unique case (r_state)
            ST_LOAD: begin
                om_we    = i_valid;
                om_wdata = (r_cnt == 4'd8) ? {55'd0, i_in_word[TopBits-1:0]} : i_in_word;
            end
            ST_RED: begin
                om_we    = red_ow.we;
                om_waddr = slot_base(ins.dst) + {2'd0, red_ow.idx};
                om_wdata = red_odata;
            end
            ST_FOLD: begin
                om_we    = r_pv && (r_pq != 4'd0);
                om_waddr = slot_base(ins.dst) + {2'd0, f_m};
                om_wdata = f_sum[63:0];
            end
            default: om_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (om_we) begin
            r_mem[om_waddr] <= om_wdata;
        end
        r_rda <= r_mem[addra];
        r_rdb <= r_mem[addrb];
    end

    m521inv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_iss   (iss),
        .i_rda   (r_rda),
        .i_rdb   (r_rdb),
        .o_pw    (pw),
        .o_pdata (pdata),
        .o_done  (mac_done)
    );

    assign red_start = (r_state == ST_DRAIN) && mac_done;

    m521inv_red u_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pw    (pw),
        .i_pdata (pdata),
        .i_start (red_start),
        .o_ow    (red_ow),
        .o_odata (red_odata),
        .o_done  (red_done)
    );

    // Final value is at most 2^521: p maps to 0 and 2^521 maps to 1.
    always_comb begin
        if (r_ones) begin
            out_fix = 64'd0;
        end else if (r_pow) begin
            out_fix = (r_q == 4'd0) ? 64'd1 : 64'd0;
        end else begin
            out_fix = r_rda;
        end
    end

    assign o_stall     = (r_state != ST_LOAD);
    assign o_valid     = r_ov;
    assign o_out_word  = r_ow;
    assign o_last_word = r_ol;

    always_ff @(posedge i_clk) begin
        if (r_rdp) begin
            r_ow <= out_fix;
            r_ol <= (r_q == 4'd8);
        end
    end

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_pc    <= '0;
            r_rep   <= '0;
            r_k     <= '0;
            r_i     <= '0;
            r_q     <= '0;
            r_pv    <= 1'b0;
            r_pq    <= '0;
            r_fc    <= 1'b0;
            r_ones  <= 1'b0;
            r_pow   <= 1'b0;
            r_rdp   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_pv <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (i_valid) begin
                        if (r_cnt == 4'd8) begin
                            r_cnt   <= '0;
                            r_pc    <= '0;
                            r_rep   <= '0;
                            r_k     <= '0;
                            r_i     <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_cnt <= r_cnt + 4'd1;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_k == 6'd33) begin
                        r_state <= ST_DRAIN;
                    end else if (col_last) begin
                        r_k <= k1;
                        r_i <= lo1;
                    end else begin
                        r_i <= r_i + 5'd1;
                    end
                end
                ST_DRAIN: begin
                    if (mac_done) begin
                        r_state <= ST_RED;
                    end
                end
                ST_RED: begin
                    if (red_done) begin
                        r_q     <= '0;
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    if (r_q <= 4'd9) begin
                        r_q  <= r_q + 4'd1;
                        r_pv <= 1'b1;
                        r_pq <= r_q;
                    end
                    if (r_pv) begin
                        r_fc <= (r_pq == 4'd0) ? r_rda[TopBits] : f_sum[64];
                    end
                    if (r_pv && (r_pq == 4'd9)) begin
                        r_k <= '0;
                        r_i <= '0;
                        r_q <= '0;
                        if (r_rep + 9'd1 == ins.reps) begin
                            r_rep <= '0;
                            if (r_pc == LastInstr) begin
                                r_ones  <= 1'b1;
                                r_pow   <= 1'b1;
                                r_state <= ST_CHK;
                            end else begin
                                r_pc    <= r_pc + 5'd1;
                                r_state <= ST_MUL;
                            end
                        end else begin
                            r_rep   <= r_rep + 9'd1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_CHK: begin
                    if (r_q <= 4'd8) begin
                        r_q  <= r_q + 4'd1;
                        r_pv <= 1'b1;
                        r_pq <= r_q;
                    end
                    if (r_pv) begin
                        if (r_pq == 4'd8) begin
                            r_ones  <= r_ones && (r_rda[9:0] == 10'h1FF);
                            r_pow   <= r_pow && (r_rda[9:0] == 10'h200);
                            r_q     <= '0;
                            r_rdp   <= 1'b0;
                            r_state <= ST_OUT;
                        end else begin
                            r_ones <= r_ones && (r_rda == {64{1'b1}});
                            r_pow  <= r_pow && (r_rda == 64'd0);
                        end
                    end
                end
                ST_OUT: begin
                    if (r_rdp) begin
                        r_rdp <= 1'b0;
                        r_ov  <= 1'b1;
                    end else if (r_ov) begin
                        if (!i_stall) begin
                            r_ov <= 1'b0;
                            if (r_q == 4'd8) begin
                                r_q     <= '0;
                                r_state <= ST_LOAD;
                            end else begin
                                r_q <= r_q + 4'd1;
                            end
                        end
                    end else begin
                        r_rdp <= 1'b1;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/m521inv_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module m521inv_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic [63:0] o_out_word,
    input wire logic        o_last_word,
    input wire logic        i_stall
);

    // A stalled result word stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_word) && $stable(o_last_word))
        else $error("stalled result word changed");

    // No input word is taken while a result is being delivered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |-> !o_valid)
        else $error("input taken during result delivery");

    // After the last result word the block is ready for the next element.
    a_last_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_word |=> !o_valid && !o_stall)
        else $error("block not released after last word");

    // The top result word is reduced below 2^521.
    a_top_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> o_out_word[63:9] == 55'd0)
        else $error("top result word too wide");

endmodule

bind mersenne_521_field_inverse m521inv_chk u_m521inv_chk (.*);

`default_nettype wire

@@ sim/mersenne_521_field_inverse_test.sv @@
`timescale 1ns / 1ps

module mersenne_521_field_inverse_test;
    import m521inv_pkg::*;

    typedef logic [520:0] t_elem;

    typedef struct {
        logic [63:0] w;
        logic        last;
    } t_word_exp;

    typedef struct {
        logic [63:0] w [9];
        logic        known;
        t_elem       inv;
    } t_elem_row;

    localparam t_elem      PRIME      = {521{1'b1}};
    localparam int         ELEMS_RAND = 21;
    localparam longint     CYCLE_CAP  = 64'd14_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic [WordW-1:0]  i_in_word;
    logic              o_stall;
    logic              o_valid;
    logic [WordW-1:0]  o_out_word;
    logic              o_last_word;
    logic              i_stall;

    t_word_exp   inverse_words_q [$];
    int          fail_count = 0;
    int          words_seen = 0;
    int          send_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    bit          hold_armed = 0;
    longint      cycle_count = 0;
    t_elem_row   directed [3];

    mersenne_521_field_inverse u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_word  (i_in_word),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_out_word (o_out_word),
        .o_last_word(o_last_word),
        .i_stall    (i_stall)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Product modulo 2^521 - 1, fully reduced.
    function automatic t_elem mul_mod_p(input t_elem a, input t_elem b);
        logic [1041:0] prod;
        logic [521:0]  sum;
        prod = {521'b0, a} * {521'b0, b};
        sum  = {1'b0, prod[520:0]} + {1'b0, prod[1041:521]};
        sum  = {1'b0, sum[520:0]} + sum[521];
        if (sum[520:0] == PRIME) begin
            sum = '0;
        end
        return sum[520:0];
    endfunction

    // Inverse by Fermat's little theorem: x^(p-2); zero and p map to zero.
    function automatic t_elem field_inverse(input t_elem x);
        t_elem acc;
        t_elem pexp;
        acc  = 521'd1;
        pexp = PRIME - 521'd2;
        if (x == PRIME) begin
            x = '0;
        end
        for (int i = 520; i >= 0; i--) begin
            acc = mul_mod_p(acc, acc);
            if (pexp[i]) begin
                acc = mul_mod_p(acc, x);
            end
        end
        return acc;
    endfunction

    // Queue the nine result words of one inverse.
    task automatic push_inverse(input t_elem r);
        t_word_exp e;
        for (int i = 0; i < 9; i++) begin
            e.w    = (i < 8) ? r[64*i +: 64] : {55'b0, r[520:512]};
            e.last = (i == 8);
            inverse_words_q.push_back(e);
        end
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(input logic [63:0] w);
        while ($urandom_range(99) < send_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Send one element; the prediction is queued once the ninth word is taken.
    task automatic send_element(input t_elem_row row);
        t_elem x;
        for (int i = 0; i < 9; i++) begin
            send_word(row.w[i]);
        end
        x = {row.w[8][8:0], row.w[7], row.w[6], row.w[5], row.w[4],
             row.w[3], row.w[2], row.w[1], row.w[0]};
        push_inverse(row.known ? row.inv : field_inverse(x));
    endtask

    // Random element, mostly dense, sometimes sparse, near p or with junk top bits.
    function automatic t_elem_row random_element();
        t_elem_row row;
        int shape;
        shape = $urandom_range(9);
        row.known = 1'b0;
        row.inv   = '0;
        for (int i = 0; i < 9; i++) begin
            row.w[i] = {$urandom, $urandom};
            if (shape == 0 && i > 0) begin
                row.w[i] = '0;
            end else if (shape == 1) begin
                row.w[i] = '1;
                if (i == 0) begin
                    row.w[i][$urandom_range(63)] = 1'b0;
                end
            end
        end
        if (shape < 6) begin
            row.w[8][63:9] = '0;
        end
        return row;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_word_exp e;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (inverse_words_q.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                fail_count++;
            end else begin
                e = inverse_words_q.pop_front();
                if (o_out_word !== e.w) begin
                    $error("out_word: expected %h, actual %h", e.w, o_out_word);
                    fail_count++;
                end
                if (o_last_word !== e.last) begin
                    $error("last_word: expected %b, actual %b", e.last, o_last_word);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall, with a long hold-off once armed.
    always @(posedge i_clk) begin
        if (hold_armed && o_valid) begin
            hold_armed = 1'b0;
            hold_left  = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_word = '0;

        // Zero, p with every bit set (junk top bits too), and p-1 which is its own inverse.
        for (int i = 0; i < 9; i++) begin
            directed[0].w[i] = '0;
            directed[1].w[i] = '1;
            directed[2].w[i] = '1;
        end
        directed[2].w[0][0] = 1'b0;
        directed[2].w[8]    = 64'h0000_0000_0000_01FF;
        directed[0].known = 1'b1;
        directed[0].inv   = '0;
        directed[1].known = 1'b1;
        directed[1].inv   = '0;
        directed[2].known = 1'b1;
        directed[2].inv   = PRIME - 521'd1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_element(directed[k]);
        end

        for (int n = 0; n < ELEMS_RAND; n++) begin
            case (n % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 69; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 69; end
                default: begin send_pct = 13; stall_pct = 13; end
            endcase
            // Hold the results off while the next element is being offered.
            if (n == 5) begin
                hold_armed = 1'b1;
            end
            // Let the pipe drain completely before this element.
            if (n == 10) begin
                i_valid <= 1'b0;
                wait (inverse_words_q.size() == 0);
                @(posedge i_clk);
            end
            send_element(random_element());
        end
        i_valid <= 1'b0;

        wait (inverse_words_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d elements (zero, p, p-1 and random), %0d result words checked.",
                 3 + ELEMS_RAND, words_seen);
        if (fail_count == 0 && inverse_words_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ mersenne_521_field_inverse.f @@
rtl/m521inv_pkg.sv
rtl/m521inv_mac.sv
rtl/m521inv_red.sv
rtl/mersenne_521_field_inverse.sv
rtl/m521inv_chk.sv
sim/mersenne_521_field_inverse_test.sv
